// ===== hw/rtl/c8raf_pkg.sv =====
// ---------------------------------------------------------------------------
// c8raf_pkg
// Types, codes and the CRC-8 byte step shared by the register access framer.
// ---------------------------------------------------------------------------
package c8raf_pkg;

    localparam int DATA_W  = 32;
    localparam int CFG_IDX_W = 8;
    localparam int BUS_ADDR_W = 7;

    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] LOW6_MASK  = 8'h3F;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BANK0_ADDR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BANK1_ADDR = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BANK2_ADDR = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BANK3_ADDR = 8'd3;

    localparam logic [BUS_ADDR_W-1:0] BANK0_ADDR_RST = 7'd78;
    localparam logic [BUS_ADDR_W-1:0] BANK1_ADDR_RST = 7'd26;
    localparam logic [BUS_ADDR_W-1:0] BANK2_ADDR_RST = 7'd100;
    localparam logic [BUS_ADDR_W-1:0] BANK3_ADDR_RST = 7'd52;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_BANK = 2'd1;
    localparam logic [1:0] ST_BAD_SIZE = 2'd2;
    localparam logic [1:0] ST_MISMATCH = 2'd3;

    localparam logic [2:0] BANK_0 = 3'd0;
    localparam logic [2:0] BANK_1 = 3'd1;
    localparam logic [2:0] BANK_2 = 3'd2;
    localparam logic [2:0] BANK_3 = 3'd3;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    // one byte through CRC-8, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/crc8_register_access_framer_top.sv =====
// ---------------------------------------------------------------------------
// crc8_register_access_framer_top
// Forms bus address and register bytes for one register access and, for a
// protected bank, runs the CRC-8 check byte over the frame, one byte per cycle.
// ---------------------------------------------------------------------------
//  channel  handshake                 payload
//  -------  ------------------------  -----------------------------------------
//  in       in_valid / in_stall       func bank reg_addr byte_count data
//                                     received_crc
//  out      out_valid / out_stall     status addr_byte encoded_reg crc_value
//                                     transfer_length read_data
//  cfg      cfg_valid / cfg_ready     cfg_index cfg_data
//
//  A protected access with no size error runs its two header bytes and then
//  its byte_count data bytes through the CRC byte step between accept and
//  result load; other accesses go from accept straight to the result load.
//  Reset loads the bank addresses with their defaults; there is no clear pass.
//  While out_stall holds a finished result, a new result waits in the run
//  state and in_stall stays high.
// ---------------------------------------------------------------------------
module crc8_register_access_framer_top
    import c8raf_pkg::*;
#(
    parameter int MAX_DATA_BYTES = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  func,
    input  logic [2:0]            bank,
    input  logic [7:0]            reg_addr,
    input  logic [2:0]            byte_count,
    input  logic [DATA_W-1:0]     data,
    input  logic [7:0]            received_crc,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic [7:0]            addr_byte,
    output logic [7:0]            encoded_reg,
    output logic [7:0]            crc_value,
    output logic [3:0]            transfer_length,
    output logic [DATA_W-1:0]     read_data,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [BUS_ADDR_W-1:0] cfg_data
);

    localparam int FRAME_W = 8 * (MAX_DATA_BYTES + 2);
    localparam int CNT_W   = $clog2(MAX_DATA_BYTES + 3);
    localparam logic [2:0] MAX_CNT = 3'(MAX_DATA_BYTES);

    state_t state_reg, state_next;

    logic [BUS_ADDR_W-1:0] bank0_addr_reg, bank1_addr_reg, bank2_addr_reg, bank3_addr_reg;

    logic [FRAME_W-1:0] frame_reg;
    logic [CNT_W-1:0]   bytes_left_reg;
    logic [7:0]         crc_reg;
    logic [1:0]         err_reg;
    logic               write_reg;
    logic               prot_reg;
    logic [2:0]         count_reg;
    logic [DATA_W-1:0]  data_reg;
    logic [7:0]         rx_crc_reg;
    logic [7:0]         addr_byte_reg;
    logic [7:0]         enc_reg;
    logic [3:0]         len_reg;

    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic [7:0]         addr_out_reg;
    logic [7:0]         enc_out_reg;
    logic [7:0]         crc_out_reg;
    logic [3:0]         len_out_reg;
    logic [DATA_W-1:0]  rdata_out_reg;

    logic               in_fire;
    logic               finish;
    logic [BUS_ADDR_W-1:0] sel_addr;
    logic               sel_prot;
    logic [1:0]         in_err;
    logic [7:0]         in_addr_byte;
    logic [7:0]         in_enc;
    logic [1:0]         size_code;
    logic [1:0]         fin_status;
    logic [DATA_W-1:0]  fin_rdata;
    logic               mismatch;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign finish    = (state_reg == S_RUN) && (bytes_left_reg == '0)
                       && (!out_valid_reg || !out_stall);

    // bank decode on the incoming beat
    always_comb
    begin
        sel_addr = bank0_addr_reg;
        sel_prot = 1'b0;
        case (bank)
            BANK_0:  sel_addr = bank0_addr_reg;
            BANK_1:
            begin
                sel_addr = bank1_addr_reg;
                sel_prot = 1'b1;
            end
            BANK_2:
            begin
                sel_addr = bank2_addr_reg;
                sel_prot = 1'b1;
            end
            BANK_3:  sel_addr = bank3_addr_reg;
            default: sel_addr = bank0_addr_reg;
        endcase

        // count 4 wraps to size code 3
        size_code = byte_count[1:0] - 2'd1;
        if (bank[2])
        begin
            in_err = ST_BAD_BANK;
        end
        else if (byte_count > MAX_CNT || (sel_prot && byte_count == 3'd0))
        begin
            in_err = ST_BAD_SIZE;
        end
        else
        begin
            in_err = ST_OK;
        end

        in_addr_byte = {sel_addr, ~func};
        in_enc       = sel_prot ? ((reg_addr & LOW6_MASK) | {size_code, 6'd0}) : reg_addr;
    end

    // result fields at the end of the run
    always_comb
    begin
        mismatch = prot_reg && !write_reg && (crc_reg != rx_crc_reg);
        if (err_reg != ST_OK)
        begin
            fin_status = err_reg;
        end
        else if (mismatch)
        begin
            fin_status = ST_MISMATCH;
        end
        else
        begin
            fin_status = ST_OK;
        end

        fin_rdata = '0;
        if (fin_status == ST_OK && !write_reg)
        begin
            for (int i = 0; i < DATA_W / 8; i++)
            begin
                if (3'(i) < count_reg)
                begin
                    fin_rdata[8*i +: 8] = data_reg[8*i +: 8];
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_RUN;
            S_RUN:   if (finish) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            bytes_left_reg <= '0;
            out_valid_reg  <= 1'b0;
            bank0_addr_reg <= BANK0_ADDR_RST;
            bank1_addr_reg <= BANK1_ADDR_RST;
            bank2_addr_reg <= BANK2_ADDR_RST;
            bank3_addr_reg <= BANK3_ADDR_RST;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BANK0_ADDR: bank0_addr_reg <= cfg_data;
                    REG_BANK1_ADDR: bank1_addr_reg <= cfg_data;
                    REG_BANK2_ADDR: bank2_addr_reg <= cfg_data;
                    REG_BANK3_ADDR: bank3_addr_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (in_fire)
            begin
                bytes_left_reg <= (sel_prot && in_err == ST_OK)
                                  ? CNT_W'(byte_count) + CNT_W'(2) : '0;
            end
            else if (bytes_left_reg != '0)
            begin
                bytes_left_reg <= bytes_left_reg - CNT_W'(1);
            end

            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            frame_reg  <= {data[8*MAX_DATA_BYTES-1:0], in_enc, in_addr_byte};
            crc_reg    <= 8'd0;
            err_reg    <= in_err;
            write_reg  <= func;
            prot_reg   <= sel_prot;
            count_reg  <= byte_count;
            data_reg   <= data;
            rx_crc_reg <= received_crc;
            if (in_err == ST_OK)
            begin
                addr_byte_reg <= in_addr_byte;
                enc_reg       <= in_enc;
                len_reg       <= {1'b0, byte_count}
                                 + (sel_prot ? (func ? 4'd2 : 4'd1) : 4'd0);
            end
            else
            begin
                addr_byte_reg <= 8'd0;
                enc_reg       <= 8'd0;
                len_reg       <= 4'd0;
            end
        end
        else if (bytes_left_reg != '0)
        begin
            crc_reg   <= crc8_byte(crc_reg, frame_reg[7:0]);
            frame_reg <= {8'd0, frame_reg[FRAME_W-1:8]};
        end

        if (finish)
        begin
            status_reg    <= fin_status;
            addr_out_reg  <= addr_byte_reg;
            enc_out_reg   <= enc_reg;
            crc_out_reg   <= (err_reg == ST_OK && prot_reg) ? crc_reg : 8'd0;
            len_out_reg   <= len_reg;
            rdata_out_reg <= fin_rdata;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign addr_byte       = addr_out_reg;
    assign encoded_reg     = enc_out_reg;
    assign crc_value       = crc_out_reg;
    assign transfer_length = len_out_reg;
    assign read_data       = rdata_out_reg;

    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_RUN)
        else $error("accepted beat did not start a run");

    a_step_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_left_reg != '0 |-> state_reg == S_RUN && !finish)
        else $error("CRC step outside run or finish with bytes left");

    a_bad_bank_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_BAD_BANK |->
            addr_out_reg == 8'd0 && len_out_reg == 4'd0 && crc_out_reg == 8'd0)
        else $error("bad bank result carries nonzero fields");

    a_mismatch_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_MISMATCH |-> rdata_out_reg == '0)
        else $error("check mismatch returned read data");

endmodule
